// ----- rtl/tlkc_pkg.sv -----
package tlkc_pkg;

   // one cache entry as it lies in the entry memory
   typedef struct packed {
      logic        valid;
      logic [31:0] key;
      logic [7:0]  height;
      logic        has_tex;
      logic [31:0] stamp;
   } entry_type;

   // request kind (tuser)
   localparam logic KIND_ACCESS = 1'b0;
   localparam logic KIND_FLUSH  = 1'b1;

   // response status (tuser)
   localparam logic [1:0] STATUS_HIT     = 2'd0;
   localparam logic [1:0] STATUS_FILLED  = 2'd1;
   localparam logic [1:0] STATUS_FAILED  = 2'd2;
   localparam logic [1:0] STATUS_FLUSHED = 2'd3;

   localparam int SLOT_W = 9;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_WRITE
   } state_type;

   // what the search unit found after a full pass
   typedef struct packed {
      logic        found;
      logic [11:0] match_idx;
      logic        match_tex;
      logic        free_found;
      logic [11:0] free_idx;
      logic [11:0] oldest_idx;
      logic        oldest_tex;
      logic        any_tex;
   } srch_result_type;

endpackage

// ----- rtl/tlkc_entry_mem.sv -----
module tlkc_entry_mem #(
   parameter int ENTRIES = 512
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  tlkc_pkg::entry_type        wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output tlkc_pkg::entry_type        rd_data
);

   tlkc_pkg::entry_type mem [ENTRIES];
   tlkc_pkg::entry_type rd_data_ff;

   // read-first: a read and a write of one address in a cycle return the old entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/tlkc_search.sv -----
module tlkc_search #(
   parameter int ENTRIES = 512
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       rd_vld,
   input  logic [$clog2(ENTRIES)-1:0] rd_idx,
   input  tlkc_pkg::entry_type        rd_data,
   input  logic [31:0]                key,
   input  logic [7:0]                 height,
   output tlkc_pkg::srch_result_type  result
);

   localparam int IDX_W = $clog2(ENTRIES);

   logic             found_ff, found_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;
   logic             match_tex_ff, match_tex_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [IDX_W-1:0] oldest_idx_ff, oldest_idx_in;
   logic [31:0]      oldest_stamp_ff, oldest_stamp_in;
   logic             oldest_tex_ff, oldest_tex_in;
   logic             any_tex_ff, any_tex_in;
   logic             is_match;

   assign is_match = rd_data.valid && (rd_data.key == key) && (rd_data.height == height);

   always_comb begin
      found_in        = found_ff;
      match_idx_in    = match_idx_ff;
      match_tex_in    = match_tex_ff;
      free_found_in   = free_found_ff;
      free_idx_in     = free_idx_ff;
      oldest_idx_in   = oldest_idx_ff;
      oldest_stamp_in = oldest_stamp_ff;
      oldest_tex_in   = oldest_tex_ff;
      any_tex_in      = any_tex_ff;
      if (start) begin
         found_in      = 1'b0;
         free_found_in = 1'b0;
         any_tex_in    = 1'b0;
      end else if (rd_vld) begin
         // first match wins
         if (!found_ff && is_match) begin
            found_in     = 1'b1;
            match_idx_in = rd_idx;
            match_tex_in = rd_data.has_tex;
         end
         if (!free_found_ff && !rd_data.valid) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx;
         end
         // strict less-than keeps the lowest index on ties
         if ((rd_idx == '0) || (rd_data.stamp < oldest_stamp_ff)) begin
            oldest_idx_in   = rd_idx;
            oldest_stamp_in = rd_data.stamp;
            oldest_tex_in   = rd_data.has_tex;
         end
         if (rd_data.valid && rd_data.has_tex) begin
            any_tex_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         any_tex_ff    <= 1'b0;
      end else begin
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         any_tex_ff    <= any_tex_in;
      end
      match_idx_ff    <= match_idx_in;
      match_tex_ff    <= match_tex_in;
      free_idx_ff     <= free_idx_in;
      oldest_idx_ff   <= oldest_idx_in;
      oldest_stamp_ff <= oldest_stamp_in;
      oldest_tex_ff   <= oldest_tex_in;
   end

   always_comb begin
      result            = '0;
      result.found      = found_ff;
      result.match_idx  = 12'(match_idx_ff);
      result.match_tex  = match_tex_ff;
      result.free_found = free_found_ff;
      result.free_idx   = 12'(free_idx_ff);
      result.oldest_idx = 12'(oldest_idx_ff);
      result.oldest_tex = oldest_tex_ff;
      result.any_tex    = any_tex_ff;
   end

endmodule

// ----- rtl/timestamp_lru_key_cache_unit.sv -----
// fully associative key cache with least-recently-used replacement by access
// stamps. every item makes one full pass over the entry memory, one entry per
// cycle through its single read port; the result is written to an output
// register and waits there while the next item is taken. an access finds the
// first matching entry, the first free entry and the oldest stamp in that
// pass, then writes the chosen slot back once the response register has room.
// a flush item clears each entry as the pass reads it and restarts the stamp
// counter at 1. after reset a clearing pass zeroes the memory; no item is
// accepted until it ends. slot reports the low 9 bits of the entry index.
module timestamp_lru_key_cache_unit #(
   parameter int ENTRIES = 512
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // lookup_key[31:0], text_height[39:32],
                                   // need_texture[40], fill_ok[41], zero pad
   input  logic        req_tuser,  // kind[0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // slot[8:0], dropped_texture[9], zero pad
   output logic [1:0]  rsp_tuser   // status[1:0]
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   tlkc_pkg::state_type state_ff, state_in;

   // captured request
   logic        kind_ff;
   logic [31:0] key_ff;
   logic [7:0]  height_ff;
   logic        need_ff;
   logic        ok_ff;

   // scan address and read pipeline
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic             rd_vld_ff;
   logic [IDX_W-1:0] rd_idx_ff;

   logic [31:0] counter_ff, counter_in;

   // response register
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic [tlkc_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                     rsp_drop_ff, rsp_drop_in;

   // memory port
   logic                rd_en;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   tlkc_pkg::entry_type wr_data;
   tlkc_pkg::entry_type rd_data;

   tlkc_pkg::srch_result_type srch;

   logic req_go;
   logic wr_go;
   logic scan_last;
   logic hit;
   logic evict;
   logic [IDX_W-1:0] slot_idx;

   assign req_go    = req_tvalid && req_tready;
   assign scan_last = (scan_idx_ff == LAST_IDX);
   // the write-back cycle waits for room in the response register
   assign wr_go     = (state_ff == tlkc_pkg::ST_WRITE) && (!rsp_tvalid_ff || rsp_tready);

   tlkc_entry_mem #(.ENTRIES(ENTRIES)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   tlkc_search #(.ENTRIES(ENTRIES)) u_search (
      .clock   (clock),
      .reset   (reset),
      .start   (req_go),
      .rd_vld  (rd_vld_ff),
      .rd_idx  (rd_idx_ff),
      .rd_data (rd_data),
      .key     (key_ff),
      .height  (height_ff),
      .result  (srch)
   );

   // slot choice for an access
   assign hit   = srch.found && (!need_ff || srch.match_tex);
   assign evict = !srch.found && !srch.free_found;
   always_comb begin
      if (srch.found) begin
         slot_idx = srch.match_idx[IDX_W-1:0];
      end else if (srch.free_found) begin
         slot_idx = srch.free_idx[IDX_W-1:0];
      end else begin
         slot_idx = srch.oldest_idx[IDX_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tlkc_pkg::ST_CLEAR: begin
            if (scan_last) begin
               state_in = tlkc_pkg::ST_IDLE;
            end
         end
         tlkc_pkg::ST_IDLE: begin
            if (req_go) begin
               state_in = tlkc_pkg::ST_SCAN;
            end
         end
         tlkc_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = tlkc_pkg::ST_LAST;
            end
         end
         tlkc_pkg::ST_LAST: begin
            state_in = tlkc_pkg::ST_WRITE;
         end
         tlkc_pkg::ST_WRITE: begin
            if (wr_go) begin
               state_in = tlkc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tlkc_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready    = 1'b0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = scan_idx_ff;
      wr_data       = '0;
      scan_idx_in   = scan_idx_ff;
      counter_in    = counter_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_drop_in   = rsp_drop_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      case (state_ff)
         tlkc_pkg::ST_CLEAR: begin
            wr_en       = 1'b1;
            scan_idx_in = scan_last ? '0 : scan_idx_ff + 1'b1;
         end
         tlkc_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            scan_idx_in = '0;
         end
         tlkc_pkg::ST_SCAN: begin
            rd_en = 1'b1;
            // a flush zeroes each entry as it is read
            wr_en       = (kind_ff == tlkc_pkg::KIND_FLUSH);
            scan_idx_in = scan_last ? '0 : scan_idx_ff + 1'b1;
         end
         tlkc_pkg::ST_LAST: begin
         end
         tlkc_pkg::ST_WRITE: begin
            if (wr_go) begin
               rsp_tvalid_in = 1'b1;
               if (kind_ff == tlkc_pkg::KIND_FLUSH) begin
                  counter_in    = 32'd1;
                  rsp_status_in = tlkc_pkg::STATUS_FLUSHED;
                  rsp_slot_in   = '0;
                  rsp_drop_in   = srch.any_tex;
               end else begin
                  wr_en       = 1'b1;
                  wr_addr     = slot_idx;
                  rsp_slot_in = tlkc_pkg::SLOT_W'(slot_idx);
                  if (hit) begin
                     wr_data.valid   = 1'b1;
                     wr_data.key     = key_ff;
                     wr_data.height  = height_ff;
                     wr_data.has_tex = srch.match_tex;
                     wr_data.stamp   = counter_ff;
                     counter_in      = counter_ff + 32'd1;
                     rsp_status_in   = tlkc_pkg::STATUS_HIT;
                     rsp_drop_in     = 1'b0;
                  end else if (ok_ff) begin
                     wr_data.valid   = 1'b1;
                     wr_data.key     = key_ff;
                     wr_data.height  = height_ff;
                     wr_data.has_tex = need_ff;
                     wr_data.stamp   = counter_ff;
                     counter_in      = counter_ff + 32'd1;
                     rsp_status_in   = tlkc_pkg::STATUS_FILLED;
                     rsp_drop_in     = evict && srch.oldest_tex;
                  end else begin
                     // failed fill leaves the slot cleared
                     rsp_status_in = tlkc_pkg::STATUS_FAILED;
                     rsp_drop_in   = evict && srch.oldest_tex;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tlkc_pkg::ST_CLEAR;
         scan_idx_ff   <= '0;
         rd_vld_ff     <= 1'b0;
         counter_ff    <= 32'd1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_idx_ff   <= scan_idx_in;
         rd_vld_ff     <= rd_en;
         counter_ff    <= counter_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rd_idx_ff     <= scan_idx_ff;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_drop_ff   <= rsp_drop_in;
      if (req_go) begin
         kind_ff   <= req_tuser;
         key_ff    <= req_tdata[31:0];
         height_ff <= req_tdata[39:32];
         need_ff   <= req_tdata[40];
         ok_ff     <= req_tdata[41];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {6'd0, rsp_drop_ff, rsp_slot_ff};

   // an accepted item always starts a pass at the first entry
   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_go |=> (state_ff == tlkc_pkg::ST_SCAN && scan_idx_ff == '0))
      else $error("accepted item did not start a scan at entry zero");

   // the last read returns in the cycle after the scan ends
   a_last_read_lands: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tlkc_pkg::ST_LAST) |-> (rd_vld_ff && rd_idx_ff == LAST_IDX))
      else $error("last entry read not in flight when scan ended");

   // a flush restarts the stamp counter
   a_flush_restarts_counter: assert property (@(posedge clock) disable iff (reset)
      (wr_go && kind_ff == tlkc_pkg::KIND_FLUSH) |=> (counter_ff == 32'd1))
      else $error("stamp counter not restarted by flush");

endmodule

// ----- dv/timestamp_lru_key_cache_unit_tb.sv -----
module timestamp_lru_key_cache_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CACHE_DEPTH   = 512;
   localparam int POOL_SIZE     = 1024;
   localparam int DIRECTED_ROWS = 17;
   localparam int RANDOM_ITEMS  = 1130;
   localparam int DRAIN_CYCLES  = 600;      // a bit more than one full pass
   localparam int CYCLE_LIMIT   = 3000000;
   localparam int HOLD_AT       = 150000;   // receiver hold-off start (cycle)
   localparam int HOLD_LEN      = 4000;
   localparam int QUIET_FROM    = 300000;   // receiver takes every cycle here
   localparam int QUIET_TO      = 420000;

   // one request item as the cache sees it
   typedef struct packed {
      logic        kind;
      logic [31:0] key;
      logic [7:0]  height;
      logic        need_tex;
      logic        fill_ok;
   } cache_req_type;

   // one response item
   typedef struct packed {
      logic [1:0]                  status;
      logic [tlkc_pkg::SLOT_W-1:0] slot;
      logic                        dropped;
   } cache_rsp_type;

   // directed row: request plus an optional hand-written expectation
   typedef struct packed {
      logic                        kind;
      logic [31:0]                 key;
      logic [7:0]                  height;
      logic                        need_tex;
      logic                        fill_ok;
      logic                        known;
      logic [1:0]                  status;
      logic [tlkc_pkg::SLOT_W-1:0] slot;
      logic                        dropped;
   } plan_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // lookup_key[31:0], text_height[39:32],
                                   // need_texture[40], fill_ok[41], zero pad
   logic        req_tuser  = 1'b0; // kind[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // slot[8:0], dropped_texture[9], zero pad
   logic [1:0]  rsp_tuser;         // status[1:0]

   timestamp_lru_key_cache_unit #(
      .ENTRIES(CACHE_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // shadow copy of the entry memory and the stamp counter
   bit          shadow_valid  [CACHE_DEPTH];
   bit [31:0]   shadow_key    [CACHE_DEPTH];
   bit [7:0]    shadow_height [CACHE_DEPTH];
   bit          shadow_tex    [CACHE_DEPTH];
   bit [31:0]   shadow_stamp  [CACHE_DEPTH];
   bit [31:0]   stamp_counter = 32'd1;

   cache_rsp_type pending_results [$];
   int          err_count   = 0;
   int          cycle_count = 0;
   int          hold_left   = 0;

   plan_row_type directed_plan [DIRECTED_ROWS];
   bit [31:0]   pool_key    [POOL_SIZE];
   bit [7:0]    pool_height [POOL_SIZE];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("** timestamp_lru_key_cache_unit: FAILED **");
      $finish;
   end

   function automatic void wipe_entry(int idx);
      shadow_valid[idx]  = 1'b0;
      shadow_key[idx]    = '0;
      shadow_height[idx] = '0;
      shadow_tex[idx]    = 1'b0;
      shadow_stamp[idx]  = '0;
   endfunction

   // advance the shadow cache by one item and return the response it gives
   function automatic cache_rsp_type cache_outcome(cache_req_type r);
      cache_rsp_type res;
      int         match_idx;
      int         pick;
      int         oldest;
      res = '{status: tlkc_pkg::STATUS_HIT, slot: '0, dropped: 1'b0};
      if (r.kind == tlkc_pkg::KIND_FLUSH) begin
         // flush: key fields ignored, slot 0, dropped if any texture was held
         for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (shadow_valid[i] && shadow_tex[i])
               res.dropped = 1'b1;
            wipe_entry(i);
         end
         stamp_counter = 32'd1;
         res.status = tlkc_pkg::STATUS_FLUSHED;
         return res;
      end
      match_idx = -1;
      for (int i = 0; i < CACHE_DEPTH && match_idx < 0; i++) begin
         if (shadow_valid[i] && shadow_key[i] == r.key && shadow_height[i] == r.height)
            match_idx = i;
      end
      if (match_idx >= 0 && (!r.need_tex || shadow_tex[match_idx])) begin
         shadow_stamp[match_idx] = stamp_counter;
         stamp_counter = stamp_counter + 32'd1;
         res.slot = match_idx[tlkc_pkg::SLOT_W-1:0];
         return res;
      end
      // a match lacking a needed texture is refilled in place
      pick = match_idx;
      if (match_idx < 0) begin
         oldest = 0;
         for (int i = 0; i < CACHE_DEPTH && pick < 0; i++) begin
            if (!shadow_valid[i])
               pick = i;
            else if (shadow_stamp[i] < shadow_stamp[oldest])
               oldest = i;
         end
         if (pick < 0) begin
            // cache full: evict the oldest stamp, lowest index on a tie
            pick = oldest;
            res.dropped = shadow_tex[oldest];
            wipe_entry(oldest);
         end
      end
      res.slot = pick[tlkc_pkg::SLOT_W-1:0];
      if (!r.fill_ok) begin
         wipe_entry(pick);
         res.status = tlkc_pkg::STATUS_FAILED;
         return res;
      end
      shadow_valid[pick]  = 1'b1;
      shadow_key[pick]    = r.key;
      shadow_height[pick] = r.height;
      shadow_tex[pick]    = r.need_tex;
      shadow_stamp[pick]  = stamp_counter;
      stamp_counter = stamp_counter + 32'd1;
      res.status = tlkc_pkg::STATUS_FILLED;
      return res;
   endfunction

   // idle for a while, then offer one item and wait for its handshake
   task automatic offer_item(input cache_req_type r, input bit idle_ok, input bit known,
                             input cache_rsp_type typed);
      cache_rsp_type want;
      int         gap;
      gap = (idle_ok && $urandom_range(0, 15) == 0) ? $urandom_range(1, 700) : 0;
      while (gap > 0 || (idle_ok && $urandom_range(0, 99) < 32)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         if (gap > 0)
            gap--;
      end
      req_tuser  <= r.kind;
      req_tdata  <= {6'b0, r.fill_ok, r.need_tex, r.height, r.key};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      want = cache_outcome(r);
      pending_results.push_back(known ? typed : want);
   endtask

   // receiver: random stalls, one long hold-off, one stretch taking every cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (cycle_count == HOLD_AT) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_LEN;
      end else if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= 32);
      end
   end

   // response checker
   always @(posedge clock) begin
      cache_rsp_type got;
      cache_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{status: rsp_tuser, slot: rsp_tdata[tlkc_pkg::SLOT_W-1:0],
                 dropped: rsp_tdata[9]};
         if (pending_results.size() == 0) begin
            $error("unexpected response: status %0d slot %0d dropped_texture %0d",
                   got.status, got.slot, got.dropped);
            err_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               err_count++;
            end
            if (got.slot !== want.slot) begin
               $error("slot: expected %0d, got %0d", want.slot, got.slot);
               err_count++;
            end
            if (got.dropped !== want.dropped) begin
               $error("dropped_texture: expected %0d, got %0d", want.dropped, got.dropped);
               err_count++;
            end
         end
      end
   end

   initial begin
      cache_req_type item;
      int         fresh_idx;
      int         pick_idx;
      int         reach;
      int         roll;

      // directed rows: kind, key, height, need, ok, known, status, slot, dropped
      directed_plan = '{
         // flush straight after reset, nothing to drop
         '{tlkc_pkg::KIND_FLUSH,  32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1,
           1'b1, tlkc_pkg::STATUS_FLUSHED, 9'd0, 1'b0},
         // lowest key and height zero land in the first free slot
         '{tlkc_pkg::KIND_ACCESS, 32'h0000_0000, 8'h00, 1'b0, 1'b1,
           1'b1, tlkc_pkg::STATUS_FILLED,  9'd0, 1'b0},
         '{tlkc_pkg::KIND_ACCESS, 32'h0000_0000, 8'h00, 1'b0, 1'b1,
           1'b1, tlkc_pkg::STATUS_HIT,     9'd0, 1'b0},
         // highest key and height with a texture
         '{tlkc_pkg::KIND_ACCESS, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1,
           1'b1, tlkc_pkg::STATUS_FILLED,  9'd1, 1'b0},
         // textured hit ignores fill_ok
         '{tlkc_pkg::KIND_ACCESS, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b0,
           1'b1, tlkc_pkg::STATUS_HIT,     9'd1, 1'b0},
         // match without texture while one is needed: refilled in place
         '{tlkc_pkg::KIND_ACCESS, 32'h0000_0000, 8'h00, 1'b1, 1'b1,
           1'b1, tlkc_pkg::STATUS_FILLED,  9'd0, 1'b0},
         // failed fill on a free slot
         '{tlkc_pkg::KIND_ACCESS, 32'h1234_5678, 8'h01, 1'b1, 1'b0,
           1'b1, tlkc_pkg::STATUS_FAILED,  9'd2, 1'b0},
         '{tlkc_pkg::KIND_ACCESS, 32'hA5A5_A5A5, 8'h80, 1'b0, 1'b1,
           1'b1, tlkc_pkg::STATUS_FILLED,  9'd2, 1'b0},
         // failed refill of a match clears that entry
         '{tlkc_pkg::KIND_ACCESS, 32'hA5A5_A5A5, 8'h80, 1'b1, 1'b0,
           1'b1, tlkc_pkg::STATUS_FAILED,  9'd2, 1'b0},
         '{tlkc_pkg::KIND_ACCESS, 32'hA5A5_A5A5, 8'h80, 1'b0, 1'b1,
           1'b0, tlkc_pkg::STATUS_HIT,     9'd0, 1'b0},
         '{tlkc_pkg::KIND_ACCESS, 32'h5A5A_5A5A, 8'h7F, 1'b1, 1'b1,
           1'b0, tlkc_pkg::STATUS_HIT,     9'd0, 1'b0},
         // same key, other height is a different entry
         '{tlkc_pkg::KIND_ACCESS, 32'h5A5A_5A5A, 8'h7E, 1'b0, 1'b1,
           1'b0, tlkc_pkg::STATUS_HIT,     9'd0, 1'b0},
         // flush with textures held
         '{tlkc_pkg::KIND_FLUSH,  32'h0000_0000, 8'h00, 1'b0, 1'b0,
           1'b1, tlkc_pkg::STATUS_FLUSHED, 9'd0, 1'b1},
         '{tlkc_pkg::KIND_FLUSH,  32'h5555_AAAA, 8'h55, 1'b0, 1'b1,
           1'b1, tlkc_pkg::STATUS_FLUSHED, 9'd0, 1'b0},
         '{tlkc_pkg::KIND_ACCESS, 32'h0000_0001, 8'h00, 1'b0, 1'b1,
           1'b1, tlkc_pkg::STATUS_FILLED,  9'd0, 1'b0},
         '{tlkc_pkg::KIND_ACCESS, 32'h8000_0000, 8'hFE, 1'b1, 1'b1,
           1'b0, tlkc_pkg::STATUS_HIT,     9'd0, 1'b0},
         '{tlkc_pkg::KIND_ACCESS, 32'h0000_0001, 8'h00, 1'b1, 1'b0,
           1'b0, tlkc_pkg::STATUS_HIT,     9'd0, 1'b0}
      };

      // key pool, height zero included on purpose
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_key[i]    = $urandom;
         pool_height[i] = 8'($urandom_range(0, 255));
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         item = '{directed_plan[i].kind, directed_plan[i].key, directed_plan[i].height,
                  directed_plan[i].need_tex, directed_plan[i].fill_ok};
         offer_item(item, 1'b1, directed_plan[i].known,
                    '{directed_plan[i].status, directed_plan[i].slot,
                      directed_plan[i].dropped});
      end

      // random part: mostly fresh pool keys so the cache fills and starts
      // evicting, reuses of recent keys for hits, a little pure noise, and
      // flushes only near the end so the full-cache phase gets a long run
      fresh_idx = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         roll          = $urandom_range(0, 99);
         item.kind     = tlkc_pkg::KIND_ACCESS;
         item.need_tex = 1'($urandom_range(0, 1));
         item.fill_ok  = ($urandom_range(0, 9) != 0);
         if (n >= 1000 && $urandom_range(0, 39) == 0) begin
            item.kind   = tlkc_pkg::KIND_FLUSH;
            item.key    = $urandom;
            item.height = 8'($urandom_range(0, 255));
         end else if (roll < 5) begin
            item.key    = $urandom;
            item.height = 8'($urandom_range(0, 255));
         end else if (roll < 75 || fresh_idx == 0) begin
            item.key    = pool_key[fresh_idx % POOL_SIZE];
            item.height = pool_height[fresh_idx % POOL_SIZE];
            fresh_idx++;
         end else begin
            // mostly recent keys (hits), sometimes far back (likely evicted)
            reach = ($urandom_range(0, 9) < 7) ? 64 : 700;
            if (reach > fresh_idx)
               reach = fresh_idx;
            pick_idx    = (fresh_idx - $urandom_range(1, reach)) % POOL_SIZE;
            item.key    = pool_key[pick_idx];
            item.height = pool_height[pick_idx];
         end
         // sender keeps valid up for a long stretch in the middle
         offer_item(item, !(n >= 400 && n < 600), 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (err_count == 0)
         $display("** timestamp_lru_key_cache_unit: PASSED **");
      else
         $display("** timestamp_lru_key_cache_unit: FAILED **");
      $finish;
   end

endmodule
